// ===== design/zcsv_pkg.sv =====
// Shared types, codes and the percent-to-gain table for the stereo volume block.
package zcsv_pkg;

  // Field widths
  localparam int SAMPLE_W  = 24;
  localparam int VOL_W     = 7;
  localparam int GAIN_W    = 17;
  localparam int GAIN_FRAC = 16;
  localparam int OP_W      = 2;

  // Stream packing
  localparam int S_TDATA_W = 56;  // left, right, volume_pct, padding
  localparam int S_TUSER_W = 3;   // opcode, channel_select
  localparam int M_TDATA_W = 64;  // left_out, right_out, left_percent, right_percent, padding

  localparam int VOL_ENTRIES = 1 << VOL_W;
  localparam int VOL_MAX     = 100;
  localparam int GAIN_DIV    = VOL_MAX * VOL_MAX;
  localparam int UNITY_GAIN  = 1 << GAIN_FRAC;

  localparam logic [VOL_W-1:0]  VOL_RESET  = VOL_W'(VOL_MAX);
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(UNITY_GAIN);

  typedef enum logic [OP_W-1:0] {
    OP_SAMPLE  = 2'd0,
    OP_VOLUME  = 2'd1,
    OP_SILENCE = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    SIGN_UNSET = 2'd0,
    SIGN_POS   = 2'd1,
    SIGN_NEG   = 2'd2
  } sign_t;

  typedef logic [GAIN_W-1:0] gain_table_t [VOL_ENTRIES];

  // Build gain = floor(p*p*65536/10000); settings above 100 never reach the table
  function automatic gain_table_t build_gain_table();
    gain_table_t tbl;
    for (int p = 0; p < VOL_ENTRIES; p++) begin
      if (p <= VOL_MAX) begin
        tbl[p] = GAIN_W'((p * p * UNITY_GAIN) / GAIN_DIV);
      end else begin
        tbl[p] = '0;
      end
    end
    return tbl;
  endfunction

  localparam gain_table_t GAIN_TABLE = build_gain_table();

endpackage

// ===== design/zero_cross_stereo_volume.sv =====
// Stereo volume control with gain changes deferred to the next zero crossing.
//
//  channel  signals                      content
//  -------  ---------------------------  ----------------------------------------
//  s_*      s_tvalid s_tready s_tdata     input item: sample frame, set volume,
//           s_tuser                       or silence frame
//  m_*      m_tvalid m_tready m_tdata     result item: scaled samples and both
//                                         volume settings
//
// An item is held in the input register and its result in the output register, and
// one item is taken every cycle while no stall on m_tready holds an item back;
// the per-channel sign check and 24x17 multiply sit between those two registers.
// Set-volume and unused-opcode items leave the input register without a result.
// rst is synchronous and restores unity gain, 100 percent and no remembered sign.
// A stall on m_tready holds the output register; the input register still takes
// an item when the one in it moves on or makes no result.
module zero_cross_stereo_volume (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [23:0] left_sample, [47:24] right_sample, [54:48] volume_pct, [55] zero
  input  logic [zcsv_pkg::S_TDATA_W-1:0]   s_tdata,
  // [1:0] opcode, [2] channel_select
  input  logic [zcsv_pkg::S_TUSER_W-1:0]   s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [23:0] left_out, [47:24] right_out, [54:48] left_percent,
  // [61:55] right_percent, [63:62] zero
  output logic [zcsv_pkg::M_TDATA_W-1:0]   m_tdata
);
  import zcsv_pkg::*;

  typedef struct packed {
    logic [GAIN_W-1:0]          gain;
    sign_t                      sign;
    logic signed [SAMPLE_W-1:0] out;
  } chan_t;

  // Update one channel's gain and sign, then scale its sample
  function automatic chan_t chan_step(input logic signed [SAMPLE_W-1:0] s,
                                      input logic [GAIN_W-1:0] g_now,
                                      input logic [GAIN_W-1:0] g_next,
                                      input sign_t ref_in);
    chan_t r;
    sign_t cur;
    sign_t held;
    logic signed [SAMPLE_W+GAIN_W:0] prod;
    cur    = (!s[SAMPLE_W-1] && (s != '0)) ? SIGN_POS : SIGN_NEG;
    held   = ref_in;
    r.gain = g_now;
    r.sign = ref_in;
    if (g_next != g_now) begin
      if (ref_in == SIGN_UNSET) begin
        held = cur;
      end
      if ((cur != held) || (s == '0)) begin
        r.gain = g_next;
        r.sign = SIGN_UNSET;
      end else begin
        r.sign = cur;
      end
    end
    prod  = $signed({{(GAIN_W+1){s[SAMPLE_W-1]}}, s}) *
            $signed({{SAMPLE_W{1'b0}}, 1'b0, r.gain});
    r.out = prod[GAIN_FRAC+SAMPLE_W-1:GAIN_FRAC];
    return r;
  endfunction

  // Input register
  logic                 in_valid;
  logic [S_TDATA_W-1:0] in_tdata;
  logic [S_TUSER_W-1:0] in_tuser;

  // Output register
  logic                 out_valid;
  logic [M_TDATA_W-1:0] out_data;

  // Channel state, index 0 left, 1 right
  logic [GAIN_W-1:0] gain_now [2];
  logic [GAIN_W-1:0] gain_next [2];
  sign_t             ref_sign [2];
  logic [VOL_W-1:0]  volume_setting [2];

  logic [GAIN_W-1:0] gain_now_next [2];
  logic [GAIN_W-1:0] gain_next_next [2];
  sign_t             ref_sign_next [2];
  logic [VOL_W-1:0]  volume_setting_next [2];

  opcode_t                    in_op;
  logic                       in_chan;
  logic [VOL_W-1:0]           in_vol;
  logic signed [SAMPLE_W-1:0] in_left;
  logic signed [SAMPLE_W-1:0] in_right;
  logic                       has_result;
  logic                       advance;
  logic                       out_load;
  chan_t                      step_l;
  chan_t                      step_r;
  logic signed [SAMPLE_W-1:0] res_left;
  logic signed [SAMPLE_W-1:0] res_right;

  // Unpack the held item
  assign in_op    = opcode_t'(in_tuser[OP_W-1:0]);
  assign in_chan  = in_tuser[OP_W];
  assign in_left  = in_tdata[SAMPLE_W-1:0];
  assign in_right = in_tdata[2*SAMPLE_W-1:SAMPLE_W];
  assign in_vol   = in_tdata[2*SAMPLE_W+VOL_W-1:2*SAMPLE_W];

  // Move the held item on when its result has room or it makes none
  assign has_result = (in_op == OP_SAMPLE) || (in_op == OP_SILENCE);
  assign advance    = in_valid && (!has_result || !out_valid || m_tready);
  assign out_load   = advance && has_result;
  assign s_tready   = !in_valid || advance;
  assign m_tvalid   = out_valid;
  assign m_tdata    = out_data;

  assign step_l = chan_step(in_left, gain_now[0], gain_next[0], ref_sign[0]);
  assign step_r = chan_step(in_right, gain_now[1], gain_next[1], ref_sign[1]);

  // Decode the held item into next state and result samples
  always_comb begin
    gain_now_next       = gain_now;
    gain_next_next      = gain_next;
    ref_sign_next       = ref_sign;
    volume_setting_next = volume_setting;
    res_left            = '0;
    res_right           = '0;
    unique case (in_op)
      OP_SAMPLE: begin
        gain_now_next[0] = step_l.gain;
        gain_now_next[1] = step_r.gain;
        ref_sign_next[0] = step_l.sign;
        ref_sign_next[1] = step_r.sign;
        res_left         = step_l.out;
        res_right        = step_r.out;
      end
      OP_VOLUME: begin
        if (in_vol <= VOL_RESET) begin
          volume_setting_next[in_chan] = in_vol;
          gain_next_next[in_chan]      = GAIN_TABLE[in_vol];
        end
      end
      OP_SILENCE: begin
        gain_now_next[0] = gain_next[0];
        gain_now_next[1] = gain_next[1];
      end
      default: begin
      end
    endcase
  end

  // Control and channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      for (int c = 0; c < 2; c++) begin
        gain_now[c]       <= GAIN_RESET;
        gain_next[c]      <= GAIN_RESET;
        ref_sign[c]       <= SIGN_UNSET;
        volume_setting[c] <= VOL_RESET;
      end
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      if (advance) begin
        gain_now       <= gain_now_next;
        gain_next      <= gain_next_next;
        ref_sign       <= ref_sign_next;
        volume_setting <= volume_setting_next;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_tdata <= s_tdata;
      in_tuser <= s_tuser;
    end
    if (out_load) begin
      out_data <= {2'b00, volume_setting_next[1], volume_setting_next[0],
                   res_right, res_left};
    end
  end

  // Silence commits both pending gains
  a_silence_commit: assert property (@(posedge clk) disable iff (rst)
    (advance && (in_op == OP_SILENCE)) |=>
      ((gain_now[0] == gain_next[0]) && (gain_now[1] == gain_next[1])))
    else $error("silence item left a pending gain uncommitted");

  // A held item that cannot move stays put
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> (in_valid && $stable(in_tdata) && $stable(in_tuser)))
    else $error("input register changed while stalled");

  // Pending gain always matches the stored volume setting
  a_gain_matches_volume: assert property (@(posedge clk) disable iff (rst)
    (gain_next[0] == GAIN_TABLE[volume_setting[0]]) &&
    (gain_next[1] == GAIN_TABLE[volume_setting[1]]))
    else $error("pending gain does not match volume setting");

  // Volume settings never leave the legal range
  a_volume_range: assert property (@(posedge clk) disable iff (rst)
    (volume_setting[0] <= VOL_RESET) && (volume_setting[1] <= VOL_RESET))
    else $error("volume setting above 100 percent");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the zero-crossing stereo volume block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import zcsv_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS   = 627;
  localparam int HOLD_CYCLES    = 400;
  localparam int HOLD_AFTER     = 200;
  localparam int TAIL_CYCLES    = 8;
  localparam int N_DIRECTED     = 23;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [SAMPLE_W-1:0] left;
    logic [SAMPLE_W-1:0] right;
    logic                ch;
    logic [VOL_W-1:0]    vol;
    logic                check;
    logic [SAMPLE_W-1:0] exp_left;
    logic [SAMPLE_W-1:0] exp_right;
    logic [VOL_W-1:0]    exp_left_pct;
    logic [VOL_W-1:0]    exp_right_pct;
  } stim_row_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] left_out;
    logic [SAMPLE_W-1:0] right_out;
    logic [VOL_W-1:0]    left_pct;
    logic [VOL_W-1:0]    right_pct;
  } frame_t;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_RANDOM,
    READY_PERIODIC
  } ready_mode_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [S_TUSER_W-1:0] s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;

  // Predictor state
  logic [GAIN_W-1:0] gain_now [2];
  logic [GAIN_W-1:0] gain_next [2];
  sign_t             ref_sign [2];
  logic [VOL_W-1:0]  vol_setting [2];

  frame_t expected_frames [$];

  int fail_count   = 0;
  int result_count = 0;
  int burst_left   = 0;
  int n_sample     = 0;
  int n_volume     = 0;
  int n_vol_skip   = 0;
  int n_silence    = 0;
  int n_unused     = 0;
  int held_cycles  = 0;

  // Sign runs for the random waveform, one per channel
  int   run_left [2] = '{0, 0};
  logic run_neg  [2] = '{1'b0, 1'b1};

  // Directed rows: op, left, right, ch, vol, check, expected left/right/left%/right%
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{OP_SAMPLE,  24'h7FFFFF, 24'h800000, 1'b0, 7'd0,   1'b1,
      24'h7FFFFF, 24'h800000, 7'd100, 7'd100},
    '{OP_SAMPLE,  24'h000000, 24'h000000, 1'b1, 7'd127, 1'b1,
      24'h000000, 24'h000000, 7'd100, 7'd100},
    '{OP_SILENCE, 24'hFFFFFF, 24'h7FFFFF, 1'b1, 7'd55,  1'b1,
      24'h000000, 24'h000000, 7'd100, 7'd100},
    '{OP_VOLUME,  24'h123456, 24'hABCDEF, 1'b0, 7'd0,   1'b0, '0, '0, '0, '0},
    '{OP_VOLUME,  24'h000000, 24'hFFFFFF, 1'b1, 7'd127, 1'b0, '0, '0, '0, '0},
    '{OP_VOLUME,  24'h000000, 24'h000000, 1'b1, 7'd101, 1'b0, '0, '0, '0, '0},
    '{OP_SAMPLE,  24'h000005, 24'hFFFFFB, 1'b0, 7'd0,   1'b0, '0, '0, '0, '0},
    '{OP_SAMPLE,  24'h000007, 24'h000003, 1'b0, 7'd0,   1'b0, '0, '0, '0, '0},
    '{OP_SAMPLE,  24'hFFFFF9, 24'hFFFFFD, 1'b0, 7'd0,   1'b0, '0, '0, '0, '0},
    '{OP_UNUSED,  24'hFFFFFF, 24'hFFFFFF, 1'b1, 7'd10,  1'b0, '0, '0, '0, '0},
    '{OP_VOLUME,  24'h000000, 24'h000000, 1'b1, 7'd50,  1'b0, '0, '0, '0, '0},
    '{OP_SAMPLE,  24'h000064, 24'h000000, 1'b0, 7'd0,   1'b0, '0, '0, '0, '0},
    '{OP_VOLUME,  24'h000000, 24'h000000, 1'b0, 7'd100, 1'b0, '0, '0, '0, '0},
    '{OP_VOLUME,  24'h000000, 24'h000000, 1'b1, 7'd100, 1'b0, '0, '0, '0, '0},
    '{OP_SILENCE, 24'h000000, 24'h000000, 1'b0, 7'd0,   1'b1,
      24'h000000, 24'h000000, 7'd100, 7'd100},
    '{OP_VOLUME,  24'h000000, 24'h000000, 1'b0, 7'd1,   1'b0, '0, '0, '0, '0},
    '{OP_VOLUME,  24'h000000, 24'h000000, 1'b1, 7'd99,  1'b0, '0, '0, '0, '0},
    '{OP_SAMPLE,  24'h800000, 24'h7FFFFF, 1'b0, 7'd0,   1'b0, '0, '0, '0, '0},
    '{OP_SAMPLE,  24'hFFFFFF, 24'hFFFFFF, 1'b0, 7'd0,   1'b0, '0, '0, '0, '0},
    '{OP_SAMPLE,  24'h000001, 24'h000001, 1'b0, 7'd0,   1'b0, '0, '0, '0, '0},
    '{OP_VOLUME,  24'h000000, 24'h000000, 1'b0, 7'd0,   1'b0, '0, '0, '0, '0},
    '{OP_SILENCE, 24'h000000, 24'h000000, 1'b0, 7'd0,   1'b1,
      24'h000000, 24'h000000, 7'd0, 7'd99},
    '{OP_SAMPLE,  24'h7FFFFF, 24'h7FFFFF, 1'b0, 7'd0,   1'b0, '0, '0, '0, '0}
  };

  zero_cross_stereo_volume dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Percent squared as a Q1.16 gain, truncated
  function automatic logic [GAIN_W-1:0] percent_gain(input logic [VOL_W-1:0] pct);
    int p;
    p = pct;
    return GAIN_W'((p * p * UNITY_GAIN) / GAIN_DIV);
  endfunction

  // Advance one channel's zero-crossing state and scale its sample
  function automatic logic [SAMPLE_W-1:0] scale_channel(input int c,
                                                        input logic signed [SAMPLE_W-1:0] s);
    sign_t  cur;
    longint prod;
    cur = (s > 0) ? SIGN_POS : SIGN_NEG;
    if (gain_next[c] != gain_now[c]) begin
      if (ref_sign[c] == SIGN_UNSET) ref_sign[c] = cur;
      if (cur != ref_sign[c] || s == 0) begin
        gain_now[c] = gain_next[c];
        ref_sign[c] = SIGN_UNSET;
      end else begin
        ref_sign[c] = cur;
      end
    end
    prod = longint'(s) * longint'(gain_now[c]);
    return prod[SAMPLE_W+GAIN_FRAC-1:GAIN_FRAC];
  endfunction

  // Apply one accepted item to the volume state; returns 1 when a frame comes out
  function automatic bit predict_volume_frame(input stim_row_t row, output frame_t res);
    res = '0;
    case (row.op)
      OP_VOLUME: begin
        if (row.vol <= VOL_MAX) begin
          vol_setting[row.ch] = row.vol;
          gain_next[row.ch]   = percent_gain(row.vol);
        end
        return 1'b0;
      end
      OP_SAMPLE: begin
        res.left_out  = scale_channel(0, row.left);
        res.right_out = scale_channel(1, row.right);
      end
      OP_SILENCE: begin
        gain_now[0] = gain_next[0];
        gain_now[1] = gain_next[1];
      end
      default: return 1'b0;
    endcase
    res.left_pct  = vol_setting[0];
    res.right_pct = vol_setting[1];
    return 1'b1;
  endfunction

  // Draw a sample that mostly follows the channel's current sign run
  function automatic logic [SAMPLE_W-1:0] next_sample(input int c);
    int                  kind;
    logic [SAMPLE_W-1:0] mag;
    if (run_left[c] == 0) begin
      run_neg[c]  = ~run_neg[c];
      run_left[c] = $urandom_range(1, 12);
    end
    run_left[c]--;
    kind = $urandom_range(0, 19);
    if (kind == 0) return '0;
    if (kind == 1) return SAMPLE_W'($urandom);
    if (kind == 2) return run_neg[c] ? 24'h800000 : 24'h7FFFFF;
    if (kind < 10) mag = SAMPLE_W'($urandom_range(1, 255));
    else           mag = SAMPLE_W'($urandom_range(1, 24'h7FFFFF));
    return run_neg[c] ? -mag : mag;
  endfunction

  // Offer one item in the sender's burst pattern, then predict it once accepted
  task automatic send_item(input stim_row_t row);
    frame_t res;
    int     gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 16);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, row.vol, row.right, row.left};
    s_tuser  <= {row.ch, row.op};
    do @(posedge clk); while (!s_tready);
    if (predict_volume_frame(row, res)) begin
      if (row.check)
        expected_frames.push_back(frame_t'{row.exp_left, row.exp_right,
                                           row.exp_left_pct, row.exp_right_pct});
      else
        expected_frames.push_back(res);
    end
    case (row.op)
      OP_SAMPLE:  n_sample++;
      OP_SILENCE: n_silence++;
      OP_VOLUME:  if (row.vol > VOL_MAX) n_vol_skip++; else n_volume++;
      default:    n_unused++;
    endcase
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // Receiver: switch between ready patterns, with one long hold-off
  ready_mode_t ready_mode  = READY_ALWAYS;
  int          phase_left  = 0;
  int          phase_cyc   = 0;
  int          period      = 2;
  int          hold_left   = 0;
  bit          hold_done   = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      held_cycles++;
      m_tready <= 1'b0;
    end else if (!hold_done && result_count >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      held_cycles++;
      m_tready <= 1'b0;
    end else begin
      if (phase_left == 0) begin
        ready_mode = ready_mode_t'($urandom_range(0, 2));
        phase_left = $urandom_range(20, 150);
        period     = $urandom_range(2, 6);
      end
      phase_left--;
      phase_cyc++;
      case (ready_mode)
        READY_ALWAYS: m_tready <= 1'b1;
        READY_RANDOM: m_tready <= ($urandom_range(0, 99) >= 35);
        default:      m_tready <= ((phase_cyc % period) != 0);
      endcase
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    frame_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_frames.size() == 0) begin
        $error("result with no item pending: m_tdata=%h", m_tdata);
        fail_count++;
      end else begin
        want = expected_frames.pop_front();
        check_field("left_out",      want.left_out,  m_tdata[23:0]);
        check_field("right_out",     want.right_out, m_tdata[47:24]);
        check_field("left_percent",  want.left_pct,  m_tdata[54:48]);
        check_field("right_percent", want.right_pct, m_tdata[61:55]);
      end
      result_count <= result_count + 1;
    end
  end

  // Stimulus: reset, directed rows, then random waveforms, volume moves, silence and unused items
  initial begin
    stim_row_t row;
    int        pick;
    int        counted;

    gain_now    = '{GAIN_RESET, GAIN_RESET};
    gain_next   = '{GAIN_RESET, GAIN_RESET};
    ref_sign    = '{SIGN_UNSET, SIGN_UNSET};
    vol_setting = '{VOL_RESET, VOL_RESET};

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) send_item(directed_rows[i]);

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      row       = '0;
      row.left  = SAMPLE_W'($urandom);
      row.right = SAMPLE_W'($urandom);
      row.ch    = 1'($urandom);
      row.vol   = VOL_W'($urandom);
      pick      = $urandom_range(0, 99);
      if (pick < 60) begin
        row.op    = OP_SAMPLE;
        row.left  = next_sample(0);
        row.right = next_sample(1);
      end else if (pick < 82) begin
        row.op  = OP_VOLUME;
        row.vol = ($urandom_range(0, 6) == 0) ? VOL_W'($urandom_range(101, 127))
                                              : VOL_W'($urandom_range(0, VOL_MAX));
      end else if (pick < 95) begin
        row.op = OP_SILENCE;
      end else begin
        row.op = OP_UNUSED;
      end
      counted++;
      send_item(row);
    end
    s_tvalid <= 1'b0;

    // Drain, then give a stray result time to show up
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d sample, %0d silence, %0d volume (+%0d out of range), %0d unused items",
             n_sample, n_silence, n_volume, n_vol_skip, n_unused);
    $display("Checked %0d results; output held off %0d cycles under back-pressure",
             result_count, held_cycles);
    if (fail_count == 0 && expected_frames.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
design/zcsv_pkg.sv
design/zero_cross_stereo_volume.sv
tb/tb.sv
